FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/pcl_pkg.sv
// Package of the process calculus lexer: widths, token codes, controller types.
// Used by the interfaces, datapath, controller, top level, checker and testbench; depends on nothing.
package pcl_pkg;

    // Default sizes and fixed field widths.
    localparam int MAX_WORD_DEF  = 16;
    localparam int POS_WIDTH_DEF = 16;
    localparam int KIND_W        = 5;
    localparam int LINE_W        = 16;
    localparam int CHAR_W        = 8;
    localparam int INDEX_W       = 4;

    // Token and error codes carried in the kind field.
    typedef enum logic [KIND_W-1:0] {
        K_IDENT        = 5'd0,
        K_NUMBER       = 5'd1,
        K_AGENT        = 5'd2,
        K_TAU          = 5'd3,
        K_SEMI         = 5'd4,
        K_LPAREN       = 5'd5,
        K_RPAREN       = 5'd6,
        K_LBRACK       = 5'd7,
        K_RBRACK       = 5'd8,
        K_LANGLE       = 5'd9,
        K_RANGLE       = 5'd10,
        K_COMMA        = 5'd11,
        K_QUOTE        = 5'd12,
        K_EQUAL        = 5'd13,
        K_DOT          = 5'd14,
        K_PLUS         = 5'd15,
        K_BAR          = 5'd16,
        K_CARET        = 5'd17,
        K_TILDE        = 5'd18,
        K_ERR_LETTER   = 5'd19,
        K_ERR_UNKNOWN  = 5'd20,
        K_ERR_TOO_LONG = 5'd21,
        K_END          = 5'd22
    } t_kind;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH_RD,
        ST_FLUSH_CHAR,
        ST_FLUSH_TOKEN,
        ST_EVENT,
        ST_END
    } t_state;

    // Source of the next result loaded into the output register.
    typedef enum logic [1:0] {
        SEL_CHAR,
        SEL_TOKEN,
        SEL_EVENT,
        SEL_END
    } t_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd_first;
        logic rd_next;
        logic load;
        t_sel sel;
        logic last;
        logic clear_word;
        logic clear_all;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush_req;
        logic event_req;
        logic end_req;
        logic word_char;
        logic word_empty;
        logic word_special;
        logic flush_final;
        logic out_free;
    } t_stat;

    // Result of the symbol lookup.
    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_sym_hit;

    // Maps one of the fifteen punctuation characters to its token code.
    function automatic t_sym_hit decode_symbol(input logic [CHAR_W-1:0] c);
        t_sym_hit r;
        r.hit  = 1'b1;
        r.kind = K_IDENT;
        case (c)
            ";":     r.kind = K_SEMI;
            "(":     r.kind = K_LPAREN;
            ")":     r.kind = K_RPAREN;
            "[":     r.kind = K_LBRACK;
            "]":     r.kind = K_RBRACK;
            "<":     r.kind = K_LANGLE;
            ">":     r.kind = K_RANGLE;
            ",":     r.kind = K_COMMA;
            "'":     r.kind = K_QUOTE;
            "=":     r.kind = K_EQUAL;
            ".":     r.kind = K_DOT;
            "+":     r.kind = K_PLUS;
            "|":     r.kind = K_BAR;
            "^":     r.kind = K_CARET;
            "~":     r.kind = K_TILDE;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // True when c is the character of the keyword "agent" at position pos.
    function automatic logic agent_char(input logic [2:0] pos, input logic [CHAR_W-1:0] c);
        logic r;
        r = 1'b0;
        case (pos)
            3'd0:    r = (c == "a");
            3'd1:    r = (c == "g");
            3'd2:    r = (c == "e");
            3'd3:    r = (c == "n");
            3'd4:    r = (c == "t");
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // True when c is the character of the keyword "tau" at position pos.
    function automatic logic tau_char(input logic [2:0] pos, input logic [CHAR_W-1:0] c);
        logic r;
        r = 1'b0;
        case (pos)
            3'd0:    r = (c == "t");
            3'd1:    r = (c == "a");
            3'd2:    r = (c == "u");
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/pcl_intf.sv
// Valid/ready channel interfaces for source bytes and result tokens.
// Depends on pcl_pkg for the field widths.
interface pcl_in_if;
    import pcl_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_byte;
    logic              byte_valid;
    logic              end_of_input;

    modport source (output valid, text_byte, byte_valid, end_of_input, input ready);
    modport sink   (input valid, text_byte, byte_valid, end_of_input, output ready);
endinterface

interface pcl_out_if;
    import pcl_pkg::*;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [LINE_W-1:0]  line;
    logic [LINE_W-1:0]  column;
    logic [CHAR_W-1:0]  text_char;
    logic [INDEX_W-1:0] char_index;
    logic               any_error;
    logic               last;

    modport source (output valid, kind, line, column, text_char, char_index, any_error, last,
                    input ready);
    modport sink   (input valid, kind, line, column, text_char, char_index, any_error, last,
                    output ready);
endinterface

FILE: rtl/core/pcl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module pcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: rtl/core/pcl_datapath.sv
// Datapath of the lexer: byte decode, position counters, word buffer and output register.
// Depends on pcl_pkg and pcl_ram; driven by pcl_controller.
module pcl_datapath #(
    parameter int MAX_WORD  = pcl_pkg::MAX_WORD_DEF,
    parameter int POS_WIDTH = pcl_pkg::POS_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pcl_pkg::t_cmd               i_cmd,
    output pcl_pkg::t_stat              o_stat,
    input  logic [pcl_pkg::CHAR_W-1:0]  i_text_byte,
    input  logic                        i_byte_valid,
    input  logic                        i_end_of_input,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [pcl_pkg::KIND_W-1:0]  o_kind,
    output logic [pcl_pkg::LINE_W-1:0]  o_line,
    output logic [pcl_pkg::LINE_W-1:0]  o_column,
    output logic [pcl_pkg::CHAR_W-1:0]  o_text_char,
    output logic [pcl_pkg::INDEX_W-1:0] o_char_index,
    output logic                        o_any_error,
    output logic                        o_last
);
    import pcl_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int IDX_W = $clog2(MAX_WORD);
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    // Position and lexer state.
    logic [POS_WIDTH-1:0] r_line, r_col;
    logic [POS_WIDTH-1:0] r_start_line, r_start_col;
    logic                 r_in_comment, r_err_seen;
    logic [LEN_W-1:0]     r_len;
    logic                 r_num, r_agent, r_tau;
    logic [IDX_W-1:0]     r_idx;

    // Pending event captured when the byte is taken.
    logic [KIND_W-1:0]    r_ev_kind;
    logic [POS_WIDTH-1:0] r_ev_line, r_ev_col;
    logic                 r_ev_err;

    // Output register.
    logic                 r_out_valid;
    logic [KIND_W-1:0]    r_out_kind;
    logic [LINE_W-1:0]    r_out_line, r_out_col;
    logic [CHAR_W-1:0]    r_out_char;
    logic [INDEX_W-1:0]   r_out_index;
    logic                 r_out_any_error, r_out_last;

    // Decode signals.
    t_sym_hit             sym;
    logic                 active, is_ws, is_nl, is_pct, is_digit, is_letter;
    logic                 err_letter, too_long, do_write, unknown, col_inc;
    logic [POS_WIDTH-1:0] col_sat, line_sat;
    logic                 n_agent, n_tau;
    logic                 word_special, flush_final, out_free;
    logic [CHAR_W-1:0]    rd_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;

    // Classify the offered byte against the current word.
    always_comb begin
        sym        = decode_symbol(i_text_byte);
        active     = i_byte_valid && !r_in_comment;
        is_ws      = (i_text_byte == " ") || (i_text_byte == "\t") || (i_text_byte == "\r");
        is_nl      = (i_text_byte == "\n");
        is_pct     = (i_text_byte == "%");
        is_digit   = (i_text_byte >= "0") && (i_text_byte <= "9");
        is_letter  = ((i_text_byte >= "a") && (i_text_byte <= "z")) ||
                     ((i_text_byte >= "A") && (i_text_byte <= "Z")) || (i_text_byte == "_");
        err_letter = active && is_letter && (r_len != '0) && r_num;
        too_long   = active && (is_digit || is_letter) && !err_letter &&
                     (r_len >= LEN_W'(MAX_WORD));
        do_write   = active && (is_digit || is_letter) && !err_letter && !too_long;
        unknown    = active && !(is_ws || is_nl || is_pct || sym.hit || is_digit || is_letter);
        col_inc    = active && (is_ws || is_pct || sym.hit || too_long || do_write || unknown);
        col_sat    = (r_col == POS_MAX) ? r_col : r_col + 1'b1;
        line_sat   = (r_line == POS_MAX) ? r_line : r_line + 1'b1;
        n_agent    = ((r_len == '0) || r_agent) && (r_len < LEN_W'(5)) &&
                     agent_char(r_len[2:0], i_text_byte);
        n_tau      = ((r_len == '0) || r_tau) && (r_len < LEN_W'(3)) &&
                     tau_char(r_len[2:0], i_text_byte);
    end

    assign word_special = (r_agent && (r_len == LEN_W'(5))) || (r_tau && (r_len == LEN_W'(3)));
    assign flush_final  = (LEN_W'(r_idx) + 1'b1) == r_len;
    assign out_free     = !r_out_valid || i_out_ready;

    // Status toward the controller.
    always_comb begin
        o_stat.flush_req    = active && (is_ws || is_nl || is_pct || sym.hit);
        o_stat.event_req    = sym.hit && active || err_letter || too_long || unknown;
        o_stat.end_req      = i_end_of_input;
        o_stat.word_char    = do_write;
        o_stat.word_empty   = (r_len == '0);
        o_stat.word_special = word_special;
        o_stat.flush_final  = flush_final;
        o_stat.out_free     = out_free;
    end

    // Word buffer read address: first character, then one step per emitted character.
    assign rd_en   = i_cmd.rd_first || i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_first ? '0 : IDX_W'(r_idx + 1'b1);

    pcl_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_WORD)
    ) u_word_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept && do_write),
        .i_wr_addr (IDX_W'(r_len)),
        .i_wr_data (i_text_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Lexer state: positions, comment flag, word length and error flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_line       <= '0;
            r_col        <= '0;
            r_in_comment <= 1'b0;
            r_err_seen   <= 1'b0;
            r_len        <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (i_byte_valid && is_nl) begin
                    r_line <= line_sat;
                    r_col  <= '0;
                end else if (col_inc) begin
                    r_col <= col_sat;
                end
                if (active && is_pct) begin
                    r_in_comment <= 1'b1;
                end else if (r_in_comment && i_byte_valid && is_nl) begin
                    r_in_comment <= 1'b0;
                end
                if (do_write) begin
                    r_len <= r_len + 1'b1;
                end
            end
            if (i_cmd.clear_word) begin
                r_len <= '0;
            end
            if (i_cmd.load && (i_cmd.sel == SEL_EVENT) && r_ev_err) begin
                r_err_seen <= 1'b1;
            end
        end
    end

    // Word attributes, event capture and read index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && do_write) begin
            r_agent <= n_agent;
            r_tau   <= n_tau;
            if (r_len == '0) begin
                r_num        <= is_digit;
                r_start_line <= r_line;
                r_start_col  <= r_col;
            end
        end
        if (i_cmd.accept) begin
            r_ev_line <= r_line;
            r_ev_col  <= unknown ? col_sat : r_col;
            r_ev_err  <= !sym.hit;
            priority if (sym.hit) begin
                r_ev_kind <= sym.kind;
            end else if (err_letter) begin
                r_ev_kind <= K_ERR_LETTER;
            end else if (too_long) begin
                r_ev_kind <= K_ERR_TOO_LONG;
            end else begin
                r_ev_kind <= K_ERR_UNKNOWN;
            end
        end
        if (rd_en) begin
            r_idx <= rd_addr;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_last      <= i_cmd.last;
            r_out_char      <= '0;
            r_out_index     <= '0;
            r_out_any_error <= 1'b0;
            unique case (i_cmd.sel)
                SEL_CHAR: begin
                    r_out_kind  <= r_num ? K_NUMBER : K_IDENT;
                    r_out_line  <= LINE_W'(r_start_line);
                    r_out_col   <= LINE_W'(r_start_col);
                    r_out_char  <= rd_data;
                    r_out_index <= INDEX_W'(r_idx);
                end
                SEL_TOKEN: begin
                    r_out_kind <= (r_agent && (r_len == LEN_W'(5))) ? K_AGENT : K_TAU;
                    r_out_line <= LINE_W'(r_start_line);
                    r_out_col  <= LINE_W'(r_start_col);
                end
                SEL_EVENT: begin
                    r_out_kind <= r_ev_kind;
                    r_out_line <= LINE_W'(r_ev_line);
                    r_out_col  <= LINE_W'(r_ev_col);
                end
                SEL_END: begin
                    r_out_kind      <= K_END;
                    r_out_line      <= LINE_W'(r_line);
                    r_out_col       <= LINE_W'(r_col);
                    r_out_any_error <= r_err_seen;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_line       = r_out_line;
    assign o_column     = r_out_col;
    assign o_text_char  = r_out_char;
    assign o_char_index = r_out_index;
    assign o_any_error  = r_out_any_error;
    assign o_last       = r_out_last;
endmodule

FILE: rtl/core/pcl_controller.sv
// Controller of the lexer: sequences word flushes, events and the end result.
// Depends on pcl_pkg; commands pcl_datapath.
module pcl_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pcl_pkg::t_stat i_stat,
    output pcl_pkg::t_cmd  o_cmd
);
    import pcl_pkg::*;

    t_state r_state, n_state;
    logic   r_pend_event, n_pend_event;
    logic   r_pend_end, n_pend_end;

    // Picks the next piece of work for the current item.
    function automatic t_state dispatch(input logic flush_first, input logic ev,
                                        input logic fin, input logic empty);
        t_state s;
        priority if (flush_first && !empty) begin
            s = ST_FLUSH_RD;
        end else if (ev) begin
            s = ST_EVENT;
        end else if (fin && !empty) begin
            s = ST_FLUSH_RD;
        end else if (fin) begin
            s = ST_END;
        end else begin
            s = ST_IDLE;
        end
        return s;
    endfunction

    // State and pending-work registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_event <= 1'b0;
            r_pend_end   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_event <= n_pend_event;
            r_pend_end   <= n_pend_end;
        end
    end

    // Next state.
    always_comb begin
        n_state      = r_state;
        n_pend_event = r_pend_event;
        n_pend_end   = r_pend_end;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_pend_event = i_stat.event_req;
                    n_pend_end   = i_stat.end_req;
                    n_state      = dispatch(i_stat.flush_req, i_stat.event_req,
                                            i_stat.end_req,
                                            i_stat.word_empty && !i_stat.word_char);
                end
            end
            ST_FLUSH_RD: begin
                n_state = i_stat.word_special ? ST_FLUSH_TOKEN : ST_FLUSH_CHAR;
            end
            ST_FLUSH_CHAR: begin
                if (i_stat.out_free && i_stat.flush_final) begin
                    n_state = dispatch(1'b0, r_pend_event, r_pend_end, 1'b1);
                end
            end
            ST_FLUSH_TOKEN: begin
                if (i_stat.out_free) begin
                    n_state = dispatch(1'b0, r_pend_event, r_pend_end, 1'b1);
                end
            end
            ST_EVENT: begin
                if (i_stat.out_free) begin
                    n_pend_event = 1'b0;
                    n_state      = dispatch(1'b0, 1'b0, r_pend_end, i_stat.word_empty);
                end
            end
            ST_END: begin
                if (i_stat.out_free) begin
                    n_pend_end = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = SEL_CHAR;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_FLUSH_RD: begin
                o_cmd.rd_first = !i_stat.word_special;
            end
            ST_FLUSH_CHAR: begin
                if (i_stat.out_free) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.sel        = SEL_CHAR;
                    o_cmd.last       = i_stat.flush_final && !r_pend_event && !r_pend_end;
                    o_cmd.clear_word = i_stat.flush_final;
                    o_cmd.rd_next    = !i_stat.flush_final;
                end
            end
            ST_FLUSH_TOKEN: begin
                if (i_stat.out_free) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.sel        = SEL_TOKEN;
                    o_cmd.last       = !r_pend_event && !r_pend_end;
                    o_cmd.clear_word = 1'b1;
                end
            end
            ST_EVENT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = SEL_EVENT;
                    o_cmd.last = !r_pend_end;
                end
            end
            ST_END: begin
                if (i_stat.out_free) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.sel       = SEL_END;
                    o_cmd.last      = 1'b1;
                    o_cmd.clear_all = 1'b1;
                end
            end
            default: o_in_ready = 1'b0;
        endcase
    end
endmodule

FILE: rtl/core/process_calculus_lexer.sv
// Top level of the process calculus lexer: controller, datapath and channel ports.
// Depends on pcl_pkg, pcl_intf, pcl_controller and pcl_datapath.
//
//   Port    Role     Carries
//   i_in    sink     text_byte, byte_valid, end_of_input
//   o_out   source   kind, line, column, text_char, char_index, any_error, last
//
// Each item is taken in the idle state; its results are then loaded one by
// one, a word flushed before the symbol that ends it and the end result last.
// Flushing a word reads the word buffer, then loads one result per character
// (one token for agent or tau). Reset is synchronous and active low; the
// output register holds a result while o_out.ready is low, and the block
// accepts a new item only after all results of the previous one are loaded.
module process_calculus_lexer #(
    parameter int MAX_WORD  = pcl_pkg::MAX_WORD_DEF,
    parameter int POS_WIDTH = pcl_pkg::POS_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcl_in_if.sink    i_in,
    pcl_out_if.source o_out
);
    import pcl_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    pcl_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pcl_datapath #(
        .MAX_WORD  (MAX_WORD),
        .POS_WIDTH (POS_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_text_byte    (i_in.text_byte),
        .i_byte_valid   (i_in.byte_valid),
        .i_end_of_input (i_in.end_of_input),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_kind         (o_out.kind),
        .o_line         (o_out.line),
        .o_column       (o_out.column),
        .o_text_char    (o_out.text_char),
        .o_char_index   (o_out.char_index),
        .o_any_error    (o_out.any_error),
        .o_last         (o_out.last)
    );

    assign i_in.ready = in_ready;
endmodule

FILE: rtl/core/pcl_checker.sv
// Port-level checks of the lexer result channel, bound to the top level.
// Depends on pcl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pcl_pkg::KIND_W-1:0]  i_kind,
    input logic [pcl_pkg::CHAR_W-1:0]  i_text_char,
    input logic [pcl_pkg::INDEX_W-1:0] i_char_index,
    input logic                        i_any_error,
    input logic                        i_last
);
    import pcl_pkg::*;

    // A stalled result stays offered and keeps its kind.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind))

    // The end result always closes its item.
    `ASSERT_SAME(a_end_last, i_clk, i_rst_n, i_out_valid && (i_kind == K_END), i_last)

    // Only the end result reports the error summary.
    `ASSERT_SAME(a_err_on_end, i_clk, i_rst_n, i_out_valid && (i_kind != K_END), !i_any_error)

    // Results other than word characters carry no character.
    `ASSERT_SAME(a_no_char, i_clk, i_rst_n, i_out_valid && (i_kind != K_IDENT) && (i_kind != K_NUMBER), (i_text_char == '0) && (i_char_index == '0))

    // Kinds stay within the defined codes.
    `ASSERT_SAME(a_kind_range, i_clk, i_rst_n, i_out_valid, i_kind <= K_END)
endmodule

bind process_calculus_lexer pcl_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_kind       (o_out.kind),
    .i_text_char  (o_out.text_char),
    .i_char_index (o_out.char_index),
    .i_any_error  (o_out.any_error),
    .i_last       (o_out.last)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench of the process calculus lexer: directed and random source text,
// every token checked field by field against a behavioral predictor.
// Depends on pcl_pkg, pcl_intf and process_calculus_lexer.
module tb;
    import pcl_pkg::*;

    // One source item waiting to be sent.
    typedef struct {
        logic [CHAR_W-1:0] text_byte;
        logic              byte_valid;
        logic              end_of_input;
        bit                paced;  // sent back to back, never followed by a gap
        bit                hold;   // sent only once every expected token has come
    } t_src_item;

    // One token as the block should produce it.
    typedef struct {
        t_kind              kind;
        logic [LINE_W-1:0]  line;
        logic [LINE_W-1:0]  column;
        logic [CHAR_W-1:0]  text_char;
        logic [INDEX_W-1:0] char_index;
        logic               any_error;
        logic               last;
    } t_token;

    localparam int                WORD_MAX = MAX_WORD_DEF;
    localparam logic [LINE_W-1:0] POS_TOP  = '1;
    localparam logic [7:0]        CH_TAB   = 8'h09;
    localparam logic [7:0]        CH_LF    = 8'h0A;
    localparam logic [7:0]        CH_CR    = 8'h0D;
    // The fifteen symbol characters in token order, first one in the top byte.
    localparam logic [8*15-1:0]   SYMBOLS  = ";()[]<>,'=.+|^~";

    logic i_clk;
    logic i_rst_n;

    pcl_in_if  src_if ();
    pcl_out_if tok_if ();

    process_calculus_lexer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (src_if),
        .o_out   (tok_if)
    );

    t_src_item pending_bytes[$];
    t_token    expected_tokens[$];
    t_token    step_tokens[$];
    int        error_count;
    int        live_items;
    bit        byte_taken;
    int        send_gap;
    int        stall_left;
    int        calm_src;
    int        calm_sink;

    // Lexer state kept by the predictor.
    logic [7:0]        lx_buf [WORD_MAX];
    int                lx_len;
    logic [LINE_W-1:0] lx_start_line;
    logic [LINE_W-1:0] lx_start_col;
    logic [LINE_W-1:0] lx_line;
    logic [LINE_W-1:0] lx_col;
    bit                lx_comment;
    bit                lx_error;

    // Clock, 20 ns period.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Prints one mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic logic [LINE_W-1:0] sat_up(input logic [LINE_W-1:0] v);
        return (v == POS_TOP) ? v : v + 1'b1;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void put_token(input t_kind k, input logic [LINE_W-1:0] ln,
                                      input logic [LINE_W-1:0] col, input logic [7:0] ch,
                                      input logic [INDEX_W-1:0] idx, input logic anyerr);
        t_token t;
        t.kind       = k;
        t.line       = ln;
        t.column     = col;
        t.text_char  = ch;
        t.char_index = idx;
        t.any_error  = anyerr;
        t.last       = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void lex_reset();
        lx_len        = 0;
        lx_start_line = '0;
        lx_start_col  = '0;
        lx_line       = '0;
        lx_col        = '0;
        lx_comment    = 1'b0;
        lx_error      = 1'b0;
    endfunction

    // Ends the buffered word: keyword token, or one token per character.
    function automatic void flush_word();
        t_kind k;
        if (lx_len == 0)
            return;
        if (lx_len == 5 && {lx_buf[0], lx_buf[1], lx_buf[2], lx_buf[3], lx_buf[4]} == "agent") begin
            put_token(K_AGENT, lx_start_line, lx_start_col, 8'd0, '0, 1'b0);
        end else if (lx_len == 3 && {lx_buf[0], lx_buf[1], lx_buf[2]} == "tau") begin
            put_token(K_TAU, lx_start_line, lx_start_col, 8'd0, '0, 1'b0);
        end else begin
            k = is_digit(lx_buf[0]) ? K_NUMBER : K_IDENT;
            for (int i = 0; i < lx_len; i++)
                put_token(k, lx_start_line, lx_start_col, lx_buf[i], INDEX_W'(i), 1'b0);
        end
        lx_len = 0;
    endfunction

    function automatic void flag_error(input t_kind k);
        lx_error = 1'b1;
        put_token(k, lx_line, lx_col, 8'd0, '0, 1'b0);
    endfunction

    // Effect of one source byte on the lexer state.
    function automatic void lex_byte(input logic [7:0] c);
        bit letter;
        if (lx_comment) begin
            if (c == CH_LF) begin
                lx_comment = 1'b0;
                lx_line    = sat_up(lx_line);
                lx_col     = '0;
            end
            return;
        end
        if (c == " " || c == CH_TAB || c == CH_CR) begin
            flush_word();
            lx_col = sat_up(lx_col);
            return;
        end
        if (c == CH_LF) begin
            flush_word();
            lx_line = sat_up(lx_line);
            lx_col  = '0;
            return;
        end
        if (c == "%") begin
            flush_word();
            lx_col     = sat_up(lx_col);
            lx_comment = 1'b1;
            return;
        end
        for (int k = 0; k < 15; k++) begin
            if (SYMBOLS[8*(14-k) +: 8] == c) begin
                flush_word();
                put_token(t_kind'(KIND_W'(int'(K_SEMI) + k)), lx_line, lx_col, 8'd0, '0, 1'b0);
                lx_col = sat_up(lx_col);
                return;
            end
        end
        letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        if (is_digit(c) || letter) begin
            // A letter inside a number is dropped and the column stays put.
            if (letter && lx_len > 0 && is_digit(lx_buf[0])) begin
                flag_error(K_ERR_LETTER);
                return;
            end
            if (lx_len >= WORD_MAX) begin
                flag_error(K_ERR_TOO_LONG);
                lx_col = sat_up(lx_col);
                return;
            end
            if (lx_len == 0) begin
                lx_start_line = lx_line;
                lx_start_col  = lx_col;
            end
            lx_buf[lx_len] = c;
            lx_len++;
            lx_col = sat_up(lx_col);
            return;
        end
        // An unknown byte is reported after its column is counted.
        lx_col = sat_up(lx_col);
        flag_error(K_ERR_UNKNOWN);
    endfunction

    // Tokens expected from one accepted item, appended to the expected queue.
    function automatic void predict_tokens(input logic [7:0] c, input logic bval,
                                           input logic eoi);
        step_tokens.delete();
        if (bval)
            lex_byte(c);
        if (eoi) begin
            flush_word();
            put_token(K_END, lx_line, lx_col, 8'd0, '0, lx_error);
            lex_reset();
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endfunction

    function automatic void queue_item(input logic [7:0] c, input logic bval, input logic eoi,
                                       input bit paced = 1'b0, input bit hold = 1'b0);
        t_src_item it;
        it.text_byte    = c;
        it.byte_valid   = bval;
        it.end_of_input = eoi;
        it.paced        = paced;
        it.hold         = hold;
        pending_bytes.insert(pending_bytes.size(), it);
        if (bval || eoi)
            live_items++;
    endfunction

    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_item(s[i], 1'b1, 1'b0);
    endfunction

    // A word character: letter or underscore, or also a digit.
    function automatic logic [7:0] word_char(input bit letters_only);
        int r;
        r = $urandom_range(0, letters_only ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return "_";
        return 8'("0" + r - 53);
    endfunction

    // Idle length: mostly none or short, now and then long, with calm stretches.
    function automatic int pick_pause(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Source driver: presents the next pending item after each transfer or gap.
    always @(negedge i_clk) begin
        t_src_item it;
        if (!i_rst_n) begin
            src_if.valid        <= 1'b0;
            src_if.text_byte    <= '0;
            src_if.byte_valid   <= 1'b0;
            src_if.end_of_input <= 1'b0;
            send_gap            <= 0;
        end else if (!src_if.valid || byte_taken) begin
            if (send_gap > 0) begin
                src_if.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (pending_bytes.size() > 0 &&
                         (!pending_bytes[0].hold || expected_tokens.size() == 0)) begin
                it = pending_bytes.pop_front();
                src_if.valid        <= 1'b1;
                src_if.text_byte    <= it.text_byte;
                src_if.byte_valid   <= it.byte_valid;
                src_if.end_of_input <= it.end_of_input;
                send_gap            <= it.paced ? 0 : pick_pause(calm_src);
            end else begin
                src_if.valid <= 1'b0;
            end
        end
    end

    // Token sink: ready with random stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tok_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            tok_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            tok_if.ready <= 1'b1;
            stall_left   <= pick_pause(calm_sink);
        end
    end

    // Monitor: predicts on each source transfer, checks each token transfer.
    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            byte_taken <= src_if.valid && src_if.ready;
            if (src_if.valid && src_if.ready)
                predict_tokens(src_if.text_byte, src_if.byte_valid, src_if.end_of_input);
            if (tok_if.valid && tok_if.ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("unexpected token kind", tok_if.kind, 0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (tok_if.kind !== want.kind)
                        report_mismatch("kind", tok_if.kind, want.kind);
                    if (tok_if.line !== want.line)
                        report_mismatch("line", tok_if.line, want.line);
                    if (tok_if.column !== want.column)
                        report_mismatch("column", tok_if.column, want.column);
                    if (tok_if.text_char !== want.text_char)
                        report_mismatch("text_char", tok_if.text_char, want.text_char);
                    if (tok_if.char_index !== want.char_index)
                        report_mismatch("char_index", tok_if.char_index, want.char_index);
                    if (tok_if.any_error !== want.any_error)
                        report_mismatch("any_error", tok_if.any_error, want.any_error);
                    if (tok_if.last !== want.last)
                        report_mismatch("last", tok_if.last, want.last);
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int  pick;
        int  n;
        int  spins;
        logic [7:0] c;
        error_count         = 0;
        live_items          = 0;
        calm_src            = 0;
        calm_sink           = 0;
        send_gap            = 0;
        stall_left          = 0;
        byte_taken          = 1'b0;
        lex_reset();
        i_rst_n             = 1'b0;
        src_if.valid        = 1'b0;
        src_if.text_byte    = '0;
        src_if.byte_valid   = 1'b0;
        src_if.end_of_input = 1'b0;
        tok_if.ready        = 1'b0;

        // Keywords; the end marker rides on the last byte and flushes "tau".
        queue_text("agent ta");
        queue_item("u", 1'b1, 1'b1);
        // A word cut short by a symbol, then every symbol.
        queue_text("x;()[]<>,'=.+|^");
        queue_item("~", 1'b1, 1'b1);
        // Letter after a digit, a comment whose bytes are ignored, unknown bytes.
        queue_text("1a2\t%");
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_item(CH_LF, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_item(8'h5A, 1'b0, 1'b0);
        // A word past the buffer size, then end items without a byte.
        queue_text("Q_012345678901234567");
        queue_item(8'hA5, 1'b0, 1'b1);
        queue_item(8'h00, 1'b0, 1'b1);
        // A symbol right after a word, an unknown byte before a number.
        queue_text("ab+!9");
        queue_item(8'h00, 1'b0, 1'b1);

        // Random text, mostly well-formed words separated by blanks or symbols.
        queue_item(" ", 1'b1, 1'b0, 1'b0, 1'b1);
        while (live_items < 120) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
                queue_item(word_char(1'b1), 1'b1, 1'b0);
                for (int i = 1; i < n; i++)
                    queue_item(word_char(1'b0), 1'b1, 1'b0);
            end else if (pick < 45) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    queue_item(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
                    if ($urandom_range(0, 7) == 0)
                        queue_item(word_char(1'b1), 1'b1, 1'b0);
                end
            end else if (pick < 55) begin
                case ($urandom_range(0, 3))
                    0:       queue_text("agent");
                    1:       queue_text("tau");
                    2:       queue_text("agents");
                    default: queue_text("ta");
                endcase
            end else if (pick < 72) begin
                queue_item(SYMBOLS[8*$urandom_range(0, 14) +: 8], 1'b1, 1'b0);
            end else if (pick < 84) begin
                case ($urandom_range(0, 3))
                    0:       queue_item(" ", 1'b1, 1'b0);
                    1:       queue_item(CH_TAB, 1'b1, 1'b0);
                    2:       queue_item(CH_CR, 1'b1, 1'b0);
                    default: queue_item(CH_LF, 1'b1, 1'b0);
                endcase
            end else if (pick < 89) begin
                queue_item("%", 1'b1, 1'b0);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) begin
                    c = 8'($urandom_range(0, 255));
                    queue_item((c == CH_LF) ? 8'h0B : c, 1'b1, 1'b0);
                end
                queue_item(CH_LF, 1'b1, 1'b0);
            end else if (pick < 95) begin
                queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end else if (pick < 97) begin
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else begin
                queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
            // Words mostly end at a separator so that the next one starts fresh.
            if (pick < 55 && $urandom_range(0, 3) != 0)
                queue_item(($urandom_range(0, 1) == 0) ? " " : SYMBOLS[8*$urandom_range(0, 14) +: 8],
                           1'b1, 1'b0);
        end
        queue_item(8'h00, 1'b0, 1'b1);

        // Reset, released at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_bytes.size() > 0 || src_if.valid)
            @(posedge i_clk);
        spins = 0;
        while (expected_tokens.size() > 0 && spins < 100000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (40) @(posedge i_clk);
        if (expected_tokens.size() > 0)
            report_mismatch("tokens never produced", expected_tokens.size(), 0);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #60_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
